### design/kpci_pkg.sv
// kpci_pkg: shared types, constants and power-sum table builder for the k-mer index block
`default_nettype none

package kpci_pkg;

   // fixed field widths
   localparam int SYM_W   = 5;
   localparam int KSIZE_W = 3;
   localparam int IDX_W   = 22;
   // length/compare width, wide enough for any max k up to 8
   localparam int LEN_W   = 4;
   // depth of the power-sum table, one entry per code of a LEN_W-bit index
   localparam int TBL_D   = 16;

   localparam logic [KSIZE_W-1:0] K_SIZE_RESET = KSIZE_W'(3);

   // edge kinds
   localparam logic [1:0] EDGE_INTERNAL = 2'd0;
   localparam logic [1:0] EDGE_LEFT     = 2'd1;
   localparam logic [1:0] EDGE_RIGHT    = 2'd2;
   localparam logic [1:0] EDGE_NONE     = 2'd3;

   typedef logic [TBL_D-1:0][IDX_W-1:0] sum_tbl_type;

   // state of the k-mer after the current symbol
   typedef struct packed {
      logic [IDX_W-1:0] partial;
      logic [LEN_W-1:0] len;
      logic             overflow;
   } kmer_type;

   typedef struct packed {
      logic [IDX_W-1:0] kmer_index;
      logic             too_long;
   } result_type;

   // entry n holds the low bits of alpha^1 + ... + alpha^min(n, max_k)
   function automatic sum_tbl_type build_sums(input int alpha, input int max_k);
      sum_tbl_type tbl;
      logic [63:0] p;
      logic [63:0] acc;
      tbl = '0;
      for (int n = 0; n < TBL_D; n++) begin
         p   = 64'd1;
         acc = 64'd0;
         for (int i = 1; i <= n && i <= max_k; i++) begin
            p   = p * 64'(alpha);
            acc = acc + p;
         end
         tbl[n] = acc[IDX_W-1:0];
      end
      return tbl;
   endfunction

endpackage

`default_nettype wire

### design/kpci_if.sv
// kpci_if: valid/ready channel interfaces for symbol requests and index responses
`default_nettype none

interface kpci_req_if;
   logic                        valid;
   logic                        ready;
   logic [kpci_pkg::SYM_W-1:0]  symbol_index;
   logic                        last;
   logic [1:0]                  edge_kind;

   modport source (output valid, output symbol_index, output last, output edge_kind,
                   input ready);
   modport sink   (input valid, input symbol_index, input last, input edge_kind,
                   output ready);
endinterface

interface kpci_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [kpci_pkg::IDX_W-1:0]  kmer_index;
   logic                        too_long;

   modport source (output valid, output kmer_index, output too_long, input ready);
   modport sink   (input valid, input kmer_index, input too_long, output ready);
endinterface

`default_nettype wire

### design/kpci_accum.sv
// kpci_accum: horner accumulator, symbol counter and overflow flag for the current k-mer
`default_nettype none

module kpci_accum #(
   parameter int ALPHABET = 20,
   parameter int MAX_K    = 5
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       accept,
   input  wire logic                       last,
   input  wire logic [kpci_pkg::SYM_W-1:0] symbol_index,
   output kpci_pkg::kmer_type              kmer_next
);

   localparam int CW = $clog2(MAX_K + 1);
   localparam logic [kpci_pkg::SYM_W-1:0] SYM_MAX = kpci_pkg::SYM_W'(ALPHABET - 1);
   localparam logic [kpci_pkg::IDX_W-1:0] ALPHA   = kpci_pkg::IDX_W'(ALPHABET);
   localparam logic [CW-1:0]              CNT_MAX = CW'(MAX_K);

   logic [kpci_pkg::IDX_W-1:0] partial_ff, partial_in;
   logic [CW-1:0]              count_ff, count_in;
   logic                       overflow_ff, overflow_in;
   logic [kpci_pkg::SYM_W-1:0] sym;
   logic                       full;

   assign sym  = (symbol_index > SYM_MAX) ? SYM_MAX : symbol_index;
   assign full = (count_ff == CNT_MAX);

   // state including the current symbol
   always_comb begin
      if (full) begin
         partial_in  = partial_ff;
         count_in    = count_ff;
         overflow_in = 1'b1;
      end else begin
         partial_in  = partial_ff * ALPHA + kpci_pkg::IDX_W'(sym);
         count_in    = count_ff + CW'(1);
         overflow_in = overflow_ff;
      end
   end

   assign kmer_next.partial  = partial_in;
   assign kmer_next.len      = kpci_pkg::LEN_W'(count_in);
   assign kmer_next.overflow = overflow_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff  <= '0;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else if (accept) begin
         if (last) begin
            partial_ff  <= '0;
            count_ff    <= '0;
            overflow_ff <= 1'b0;
         end else begin
            partial_ff  <= partial_in;
            count_ff    <= count_in;
            overflow_ff <= overflow_in;
         end
      end
   end

endmodule

`default_nettype wire

### design/kpci_correct.sv
// kpci_correct: edge-dependent position correction and length check
`default_nettype none

module kpci_correct #(
   parameter int ALPHABET = 20,
   parameter int MAX_K    = 5
) (
   input  wire kpci_pkg::kmer_type               kmer,
   input  wire logic [kpci_pkg::KSIZE_W-1:0]     k_size,
   input  wire logic [1:0]                       edge_kind,
   output kpci_pkg::result_type                  result
);

   localparam kpci_pkg::sum_tbl_type SUMS = kpci_pkg::build_sums(ALPHABET, MAX_K);
   localparam logic [kpci_pkg::LEN_W-1:0] K_MAX = kpci_pkg::LEN_W'(MAX_K);

   logic [kpci_pkg::LEN_W-1:0] k_raw, k_eff, k_m1, len_m1;
   logic                       flag;
   logic [kpci_pkg::IDX_W-1:0] idx;

   assign k_raw = kpci_pkg::LEN_W'(k_size);

   // zero counts as one, anything above the maximum is clipped
   always_comb begin
      priority if (k_raw == '0) begin
         k_eff = kpci_pkg::LEN_W'(1);
      end else if (k_raw > K_MAX) begin
         k_eff = K_MAX;
      end else begin
         k_eff = k_raw;
      end
   end

   assign k_m1    = k_eff - kpci_pkg::LEN_W'(1);
   assign len_m1  = kmer.len - kpci_pkg::LEN_W'(1);

   assign flag = kmer.overflow || (kmer.len > k_eff);

   // right edge: sum(len+1..k) taken as sum(1..k) - sum(1..len)
   always_comb begin
      unique case (edge_kind)
         kpci_pkg::EDGE_INTERNAL: idx = kmer.partial + SUMS[k_m1];
         kpci_pkg::EDGE_LEFT:     idx = kmer.partial + SUMS[len_m1];
         kpci_pkg::EDGE_RIGHT:    idx = kmer.partial + SUMS[k_eff] - SUMS[kmer.len]
                                        + SUMS[k_m1];
         default:                 idx = kmer.partial;
      endcase
   end

   assign result.kmer_index = flag ? '0 : idx;
   assign result.too_long   = flag;

endmodule

`default_nettype wire

### design/kmer_position_corrected_index.sv
// kmer_position_corrected_index: top level of the position-corrected k-mer indexer
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  req     | in        | valid/ready        | symbol_index[4:0], last, edge_kind[1:0]
//  rsp     | out       | valid/ready        | kmer_index[21:0], too_long
//  csr     | in        | write enable only  | k_size[2:0]
//
//  one symbol transaction per cycle while req ready is high; a response appears the
//  cycle after its last symbol; the horner step and the correction add are both
//  combinational between the accumulator and the response register
//  req ready drops only while a response sits unaccepted and rsp ready is low
//  reset (synchronous) clears the k-mer state, empties the response register and
//  sets k_size to 3
`default_nettype none

module kmer_position_corrected_index #(
   parameter int ALPHABET = 20,
   parameter int MAX_K    = 5
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   kpci_req_if.sink                           req_chan,
   kpci_rsp_if.source                         rsp_chan,
   input  wire logic                          csr_wr_en,
   input  wire logic [kpci_pkg::KSIZE_W-1:0]  csr_wr_data
);

   // configuration register
   logic [kpci_pkg::KSIZE_W-1:0] k_size_ff;

   // response register
   logic                         rsp_valid_ff, rsp_valid_in;
   kpci_pkg::result_type         rsp_data_ff;

   kpci_pkg::kmer_type           kmer_next;
   kpci_pkg::result_type         result;
   logic                         req_accept;
   logic                         rsp_accept;

   // a new transaction may enter whenever the response slot is free or draining
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign rsp_accept     = rsp_valid_ff && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_size_ff <= kpci_pkg::K_SIZE_RESET;
      end else if (csr_wr_en) begin
         k_size_ff <= csr_wr_data;
      end
   end

   // horner accumulation of the symbols of the current k-mer
   kpci_accum #(
      .ALPHABET (ALPHABET),
      .MAX_K    (MAX_K)
   ) u_accum (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .last         (req_chan.last),
      .symbol_index (req_chan.symbol_index),
      .kmer_next    (kmer_next)
   );

   // correction by edge kind, computed from the state that includes this symbol
   kpci_correct #(
      .ALPHABET (ALPHABET),
      .MAX_K    (MAX_K)
   ) u_correct (
      .kmer      (kmer_next),
      .k_size    (k_size_ff),
      .edge_kind (req_chan.edge_kind),
      .result    (result)
   );

   // load on an accepted last symbol, otherwise clear once taken
   always_comb begin
      priority if (req_accept && req_chan.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_accept) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_chan.last) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.kmer_index = rsp_data_ff.kmer_index;
   assign rsp_chan.too_long   = rsp_data_ff.too_long;

endmodule

`default_nettype wire

### design/kpci_checker.sv
// kpci_checker: port-level assertions for the k-mer indexer and their bind
`default_nettype none

module kpci_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        req_last,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [kpci_pkg::IDX_W-1:0]  rsp_kmer_index,
   input wire logic                        rsp_too_long
);

   logic req_last_acc;
   assign req_last_acc = req_valid && req_ready && req_last;

   // the response slot is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // every accepted last symbol yields a response in the next cycle
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_last_acc |=> rsp_valid)
      else $error("no response after last symbol");

   // a response only appears after a last symbol
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_last_acc))
      else $error("response without last symbol");

   // a flagged k-mer reports a zero index
   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_too_long) |-> (rsp_kmer_index == '0))
      else $error("flagged response with nonzero index");

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_kmer_index)
                                     && $stable(rsp_too_long)))
      else $error("stalled response changed");

endmodule

bind kmer_position_corrected_index kpci_checker u_kpci_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .req_last       (req_chan.last),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_kmer_index (rsp_chan.kmer_index),
   .rsp_too_long   (rsp_chan.too_long)
);

`default_nettype wire
